@@ hdl/rld_pkg.sv @@
// Shared types, constants and arithmetic helpers for the rational lens distortion block.
// Depends on nothing; every other file imports it.
`default_nettype none
package rld_pkg;

   localparam int CoordWidth = 32;
   localparam int CoefWidth  = 32;
   localparam int IntWidth   = 41;
   localparam int NumRegs    = 8;
   localparam int CsrIdxWidth = 3;

   // Gain divider: quotient bits and pipeline depth (input register, steps, output).
   localparam int DivQBits = 64;
   localparam int DivLat   = DivQBits + 2;

   // Saturation magnitude of the internal values: 2^39 - 1.
   localparam logic signed [IntWidth-1:0] SatMax = 41'sh7F_FFFF_FFFF;
   localparam logic signed [IntWidth-1:0] OneQ24 = 41'sh00_0100_0000;

   // Register indexes on the configuration port.
   typedef enum logic [CsrIdxWidth-1:0] {
      REG_K1 = 3'd0, REG_K2 = 3'd1, REG_K3 = 3'd2, REG_K4 = 3'd3,
      REG_K5 = 3'd4, REG_K6 = 3'd5, REG_P1 = 3'd6, REG_P2 = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic signed [CoefWidth-1:0] k1;
      logic signed [CoefWidth-1:0] k2;
      logic signed [CoefWidth-1:0] k3;
      logic signed [CoefWidth-1:0] k4;
      logic signed [CoefWidth-1:0] k5;
      logic signed [CoefWidth-1:0] k6;
      logic signed [CoefWidth-1:0] p1;
      logic signed [CoefWidth-1:0] p2;
   } coef_type;

   // Saturate a value to magnitude SatMax.
   function automatic logic signed [IntWidth-1:0] sat_m(
      input logic signed [IntWidth+1:0] v, output logic ovf);
      logic signed [IntWidth+1:0] lim;
      lim = {{2{SatMax[IntWidth-1]}}, SatMax};
      ovf = (v > lim) || (v < -lim);
      if (v > lim) sat_m = SatMax;
      else if (v < -lim) sat_m = -SatMax;
      else sat_m = v[IntWidth-1:0];
   endfunction

   // Post-process an exact product: divide by 2^sh toward zero, saturate.
   function automatic logic signed [IntWidth-1:0] scale_prod(
      input logic signed [2*IntWidth-1:0] p, input int sh, output logic ovf);
      logic [2*IntWidth-1:0] m;
      logic [2*IntWidth-1:0] q;
      m = p[2*IntWidth-1] ? (~p + 1'b1) : p;
      q = m >> sh;
      ovf = (q > {{(IntWidth+1){1'b0}}, SatMax[IntWidth-2:0]});
      if (ovf) q = {{(IntWidth+1){1'b0}}, SatMax[IntWidth-2:0]};
      scale_prod = p[2*IntWidth-1] ? -$signed(q[IntWidth-1:0]) : $signed(q[IntWidth-1:0]);
   endfunction

endpackage
`default_nettype wire

@@ hdl/rational_lens_distortion.sv @@
// Top level of the rational lens distortion pipeline: registers, pipeline stages, output register.
// Depends on rld_pkg, rld_mul and rld_div.
//
//  channel  | direction | fields (low bit first)
//  req_     | in        | tdata: x_norm[31:0], y_norm[63:32]
//  rsp_     | out       | tdata: x_dist[31:0], y_dist[63:32]; tuser: range_error
//  csr_     | in        | wr_en, idx[2:0], data[31:0]
//
// One item enters per cycle while the pipeline is not stalled.
// The pipeline advances as one unit whenever its output register is empty or taken;
// a stalled output holds everything, and req_tready follows rsp_tready
// combinationally while the output register is full. Synchronous reset clears the
// valid bits and the coefficient registers.
`default_nettype none
module rational_lens_distortion
   import rld_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [63:0]            req_tdata,   // x_norm, y_norm
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [63:0]                 rsp_tdata,   // x_dist, y_dist
   output logic                        rsp_tuser,   // range_error
   input  wire logic                   csr_wr_en,
   input  wire logic [CsrIdxWidth-1:0] csr_idx,
   input  wire logic [CoefWidth-1:0]   csr_data
);
   // Stage map, in order: squares and r2, three Horner steps, polynomials into the divider,
   // gain, radial/tangential products, then out.
   localparam int Lat = 17 + DivLat;

   coef_type c_ff;
   logic adv;
   logic [Lat-1:0] vld_ff;
   logic out_vld_ff;
   logic [63:0] out_data_ff;
   logic out_user_ff;

   // Coefficient registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (reg_idx_type'(csr_idx))
            REG_K1: c_ff.k1 <= csr_data;
            REG_K2: c_ff.k2 <= csr_data;
            REG_K3: c_ff.k3 <= csr_data;
            REG_K4: c_ff.k4 <= csr_data;
            REG_K5: c_ff.k5 <= csr_data;
            REG_K6: c_ff.k6 <= csr_data;
            REG_P1: c_ff.p1 <= csr_data;
            REG_P2: c_ff.p2 <= csr_data;
            default: c_ff <= c_ff;
         endcase
      end
   end

   assign adv = !out_vld_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[Lat-2:0], req_tvalid};
   end

   function automatic logic signed [IntWidth-1:0] sx(input logic [31:0] v);
      sx = {{(IntWidth-32){v[31]}}, v};
   endfunction

   // Stage 0 inputs and generic delay lines.
   logic signed [IntWidth-1:0] x_in, y_in;
   assign x_in = sx(req_tdata[31:0]);
   assign y_in = sx(req_tdata[63:32]);

   // Squares and cross product (two-stage multipliers, shift 28).
   logic signed [IntWidth-1:0] xx_p, yy_p, xy_p;
   logic xx_o, yy_o, xy_o;
   rld_mul u_xx (.clock, .enable(adv), .shift28(1'b1), .a(x_in), .b(x_in), .prod(xx_p), .ovf(xx_o));
   rld_mul u_yy (.clock, .enable(adv), .shift28(1'b1), .a(y_in), .b(y_in), .prod(yy_p), .ovf(yy_o));
   rld_mul u_xy (.clock, .enable(adv), .shift28(1'b1), .a(x_in), .b(y_in), .prod(xy_p), .ovf(xy_o));

   // r2 from exact squares: both < 2^36 so the sum of floors differs; recompute exact.
   logic [63:0] ax2_ff, ay2_ff;
   logic [31:0] ax, ay;
   assign ax = req_tdata[31] ? (~req_tdata[31:0] + 1'b1) : req_tdata[31:0];
   assign ay = req_tdata[63] ? (~req_tdata[63:32] + 1'b1) : req_tdata[63:32];
   always_ff @(posedge clock) if (adv) begin
      ax2_ff <= {32'd0, ax} * {32'd0, ax};
      ay2_ff <= {32'd0, ay} * {32'd0, ay};
   end
   logic signed [IntWidth-1:0] r2_ff;
   logic [64:0] r2sum;
   assign r2sum = {1'b0, ax2_ff} + {1'b0, ay2_ff};
   always_ff @(posedge clock) if (adv) r2_ff <= {4'd0, r2sum[64:28]};

   // Once r2_ff, xx_p, yy_p, xy_p are all valid, carry them alongside.
   localparam int CarryLen = Lat;
   logic signed [IntWidth-1:0] r2_d [CarryLen];
   logic signed [IntWidth-1:0] xx_d [CarryLen], yy_d [CarryLen], xy_d [CarryLen];
   logic signed [IntWidth-1:0] x_d [CarryLen], y_d [CarryLen];
   logic ef_d [CarryLen];
   always_ff @(posedge clock) if (adv) begin
      x_d[0] <= x_in;  y_d[0] <= y_in;
      r2_d[0] <= r2_ff; xx_d[0] <= xx_p; yy_d[0] <= yy_p; xy_d[0] <= xy_p;
      ef_d[0] <= xy_o | xx_o | yy_o;
      for (int i = 1; i < CarryLen; i++) begin
         x_d[i] <= x_d[i-1];  y_d[i] <= y_d[i-1];
         r2_d[i] <= r2_d[i-1]; xx_d[i] <= xx_d[i-1];
         yy_d[i] <= yy_d[i-1]; xy_d[i] <= xy_d[i-1];
         ef_d[i] <= ef_d[i-1];
      end
   end
   // x_d[0] registers the input and r2_d[0] registers r2_ff; each tap k is one register past tap k-1.

   // Horner: two polynomials, three multiply-add steps each.
   logic signed [IntWidth-1:0] hn_p [3], hd_p [3];
   logic hn_o [3], hd_o [3];
   logic signed [IntWidth-1:0] an_ff [3], ad_ff [3];
   logic af_ff [3];
   logic signed [IntWidth-1:0] mn_a [3], md_a [3];
   logic signed [IntWidth-1:0] cn [3], cd [3];
   assign cn[0] = sx(c_ff.k2); assign cn[1] = sx(c_ff.k1); assign cn[2] = OneQ24;
   assign cd[0] = sx(c_ff.k5); assign cd[1] = sx(c_ff.k4); assign cd[2] = OneQ24;
   assign mn_a[0] = sx(c_ff.k3);
   assign md_a[0] = sx(c_ff.k6);
   assign mn_a[1] = an_ff[0]; assign mn_a[2] = an_ff[1];
   assign md_a[1] = ad_ff[0]; assign md_a[2] = ad_ff[1];

   // Step j multiplies using r2_d[4j]; its sums register in an_1/ad_1, then an_ff/ad_ff.
   for (genvar j = 0; j < 3; j++) begin : g_horner
      logic signed [IntWidth-1:0] sn, sd;
      logic on, od;
      logic prev_f;
      rld_mul u_n (.clock, .enable(adv), .shift28(1'b1), .a(mn_a[j]), .b(r2_d[4*j]),
                   .prod(hn_p[j]), .ovf(hn_o[j]));
      rld_mul u_d (.clock, .enable(adv), .shift28(1'b1), .a(md_a[j]), .b(r2_d[4*j]),
                   .prod(hd_p[j]), .ovf(hd_o[j]));
      always_comb begin
         sn = sat_m({{2{cn[j][IntWidth-1]}}, cn[j]} + {{2{hn_p[j][IntWidth-1]}}, hn_p[j]}, on);
         sd = sat_m({{2{cd[j][IntWidth-1]}}, cd[j]} + {{2{hd_p[j][IntWidth-1]}}, hd_p[j]}, od);
      end
      if (j == 0) begin : g_f0
         assign prev_f = 1'b0;
      end else begin : g_fn
         assign prev_f = af_ff[j-1];
      end
      // The earlier flag travels beside the product through the multiplier's two stages.
      logic signed [IntWidth-1:0] an_1, ad_1;
      logic af_1;
      logic pd_1, pd_2;
      always_ff @(posedge clock) if (adv) begin
         an_1 <= sn; ad_1 <= sd;
         pd_1 <= prev_f; pd_2 <= pd_1;
         af_1 <= on | od | hn_o[j] | hd_o[j] | pd_2;
         an_ff[j] <= an_1; ad_ff[j] <= ad_1; af_ff[j] <= af_1;
      end
   end
   // Polynomials ready at the last Horner step's output (an_ff[2]).
   localparam int PStage = 15;

   // Divider: signs carried alongside.
   logic [IntWidth-2:0] q;
   logic q_o;
   rld_div u_div (.clock, .enable(adv),
                  .num_mag(an_ff[2][IntWidth-1] ? 40'(-an_ff[2]) : an_ff[2][IntWidth-2:0]),
                  .den_mag(ad_ff[2][IntWidth-1] ? 40'(-ad_ff[2]) : ad_ff[2][IntWidth-2:0]),
                  .quot(q), .ovf(q_o));
   logic [DivLat-1:0] sg_d, dz_d, pf_d;
   always_ff @(posedge clock) if (adv) begin
      sg_d <= {sg_d[DivLat-2:0], an_ff[2][IntWidth-1] ^ ad_ff[2][IntWidth-1]};
      dz_d <= {dz_d[DivLat-2:0], ad_ff[2] == '0};
      pf_d <= {pf_d[DivLat-2:0], af_ff[2]};
   end
   localparam int GStage = PStage + DivLat;
   logic signed [IntWidth-1:0] g;
   assign g = sg_d[DivLat-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});

   // Radial and tangential products (shift 24).
   localparam int K = GStage - 1;
   logic signed [IntWidth-1:0] tx1_b, tx2_b, ty1_b;
   assign tx1_b = xy_d[K-2] <<< 1;
   assign tx2_b = r2_d[K-2] + (xx_d[K-2] <<< 1);
   assign ty1_b = r2_d[K-2] + (yy_d[K-2] <<< 1);
   logic signed [IntWidth-1:0] rx_p, ry_p, a1_p, a2_p, b1_p, b2_p;
   logic rx_o, ry_o, a1_o, a2_o, b1_o, b2_o;
   rld_mul u_rx (.clock, .enable(adv), .shift28(1'b0), .a(x_d[K]), .b(g), .prod(rx_p), .ovf(rx_o));
   rld_mul u_ry (.clock, .enable(adv), .shift28(1'b0), .a(y_d[K]), .b(g), .prod(ry_p), .ovf(ry_o));
   rld_mul u_a1 (.clock, .enable(adv), .shift28(1'b0), .a(sx(c_ff.p1)), .b(tx1_b),
                 .prod(a1_p), .ovf(a1_o));
   rld_mul u_a2 (.clock, .enable(adv), .shift28(1'b0), .a(sx(c_ff.p2)), .b(tx2_b),
                 .prod(a2_p), .ovf(a2_o));
   rld_mul u_b1 (.clock, .enable(adv), .shift28(1'b0), .a(sx(c_ff.p1)), .b(ty1_b),
                 .prod(b1_p), .ovf(b1_o));
   rld_mul u_b2 (.clock, .enable(adv), .shift28(1'b0), .a(sx(c_ff.p2)), .b(tx1_b),
                 .prod(b2_p), .ovf(b2_o));
   logic fl_a, dz_a;
   always_ff @(posedge clock) if (adv) begin
      fl_a <= pf_d[DivLat-1] | q_o | ef_d[K-2];
      dz_a <= dz_d[DivLat-1];
   end
   logic fl_b, dz_b;
   always_ff @(posedge clock) if (adv) begin
      fl_b <= fl_a; dz_b <= dz_a;
   end

   // Tangential sums and final 32-bit saturation.
   logic signed [IntWidth-1:0] dx, dy;
   logic dxo, dyo;
   logic signed [IntWidth+1:0] fx, fy;
   logic [31:0] ox, oy;
   logic oxo, oyo, flag;
   always_comb begin
      dx = sat_m({{2{a1_p[IntWidth-1]}}, a1_p} + {{2{a2_p[IntWidth-1]}}, a2_p}, dxo);
      dy = sat_m({{2{b1_p[IntWidth-1]}}, b1_p} + {{2{b2_p[IntWidth-1]}}, b2_p}, dyo);
      fx = {{2{rx_p[IntWidth-1]}}, rx_p} + {{2{dx[IntWidth-1]}}, dx};
      fy = {{2{ry_p[IntWidth-1]}}, ry_p} + {{2{dy[IntWidth-1]}}, dy};
      oxo = (fx > 43'sd2147483647) || (fx < -43'sd2147483648);
      oyo = (fy > 43'sd2147483647) || (fy < -43'sd2147483648);
      ox = (fx > 43'sd2147483647) ? 32'h7FFF_FFFF :
           (fx < -43'sd2147483648) ? 32'h8000_0000 : fx[31:0];
      oy = (fy > 43'sd2147483647) ? 32'h7FFF_FFFF :
           (fy < -43'sd2147483648) ? 32'h8000_0000 : fy[31:0];
      flag = fl_b | rx_o | ry_o | a1_o | a2_o | b1_o | b2_o | dxo | dyo | oxo | oyo;
   end

   // Output register holding one finished transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[Lat-1];
      end
   end
   always_ff @(posedge clock) if (adv) begin
      out_data_ff <= dz_b ? 64'd0 : {oy, ox};
      out_user_ff <= dz_b | flag;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // A stalled output holds its data.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output changed under stall");
   // Input is accepted exactly when the pipeline advances.
   a_adv: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready mismatch");
   // Reset empties the output register.
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");
endmodule
`default_nettype wire

@@ hdl/rld_mul.sv @@
// Pipelined multiply unit: signed 41x41 product, divided by a power of two and saturated.
// Depends on rld_pkg. Two register stages: partial products, then sum and scaling.
`default_nettype none
module rld_mul
   import rld_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        enable,
   input  wire logic                        shift28,
   input  wire logic signed [IntWidth-1:0]  a,
   input  wire logic signed [IntWidth-1:0]  b,
   output logic signed [IntWidth-1:0]       prod,
   output logic                             ovf
);
   logic [IntWidth-1:0] ma, mb;
   logic [2*IntWidth-1:0] pll_in, plh_in, phl_in, phh_in;
   logic [2*IntWidth-1:0] pll_ff, plh_ff, phl_ff, phh_ff;
   logic neg_ff, sh_ff;
   logic [2*IntWidth-1:0] sum;
   logic signed [2*IntWidth-1:0] sp;
   logic signed [IntWidth-1:0] prod_ff;
   logic ovf_ff, o;
   logic signed [IntWidth-1:0] r;

   // Magnitudes split into a 21-bit low and 20-bit high half.
   always_comb begin
      ma = a[IntWidth-1] ? (~a + 1'b1) : a;
      mb = b[IntWidth-1] ? (~b + 1'b1) : b;
      pll_in = {{(2*IntWidth-42){1'b0}}, {21'd0, ma[20:0]} * {21'd0, mb[20:0]}};
      plh_in = {{(2*IntWidth-42){1'b0}}, {21'd0, ma[20:0]} * {21'd0, mb[40:21]}} << 21;
      phl_in = {{(2*IntWidth-42){1'b0}}, {21'd0, ma[40:21]} * {21'd0, mb[20:0]}} << 21;
      phh_in = {{(2*IntWidth-42){1'b0}}, {21'd0, ma[40:21]} * {21'd0, mb[40:21]}} << 42;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         pll_ff <= pll_in;
         plh_ff <= plh_in;
         phl_ff <= phl_in;
         phh_ff <= phh_in;
         neg_ff <= a[IntWidth-1] ^ b[IntWidth-1];
         sh_ff  <= shift28;
      end
   end

   // Sum the partial products, restore the sign, scale and saturate.
   always_comb begin
      sum = pll_ff + plh_ff + phl_ff + phh_ff;
      sp = neg_ff ? -$signed(sum) : $signed(sum);
      r = scale_prod(sp, sh_ff ? 28 : 24, o);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= r;
         ovf_ff  <= o;
      end
   end

   assign prod = prod_ff;
   assign ovf  = ovf_ff;
endmodule
`default_nettype wire

@@ hdl/rld_div.sv @@
// Pipelined restoring divider for the radial gain: |N|*2^24 / |D|, one quotient bit per stage.
// Depends on rld_pkg. Stages: input register, one step per quotient bit, output register.
`default_nettype none
module rld_div
   import rld_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       enable,
   input  wire logic [IntWidth-2:0]        num_mag,
   input  wire logic [IntWidth-2:0]        den_mag,
   output logic [IntWidth-2:0]             quot,
   output logic                            ovf
);
   localparam int QBits = DivQBits;
   localparam int RemW  = IntWidth;

   logic [QBits-1:0]   dvd_ff [QBits+1];
   logic [QBits-1:0]   q_ff   [QBits+1];
   logic [RemW-1:0]    rem_ff [QBits+1];
   logic [IntWidth-2:0] dsr_ff [QBits+1];
   logic [IntWidth-2:0] quot_ff;
   logic ovf_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         dvd_ff[0] <= QBits'({num_mag, 24'd0});
         q_ff[0]   <= '0;
         rem_ff[0] <= '0;
         dsr_ff[0] <= den_mag;
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar i = 0; i < QBits; i++) begin : g_step
      logic [RemW:0] trial;
      logic [RemW-1:0] sh;
      always_comb begin
         sh = {rem_ff[i][RemW-2:0], dvd_ff[i][QBits-1]};
         trial = {1'b0, sh} - {2'b0, dsr_ff[i]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            dvd_ff[i+1] <= dvd_ff[i] << 1;
            dsr_ff[i+1] <= dsr_ff[i];
            rem_ff[i+1] <= trial[RemW] ? sh : trial[RemW-1:0];
            q_ff[i+1]   <= {q_ff[i][QBits-2:0], ~trial[RemW]};
         end
      end
   end

   // Saturate the quotient to 2^39 - 1.
   always_ff @(posedge clock) begin
      if (enable) begin
         ovf_ff  <= (q_ff[QBits] > {{(QBits-IntWidth+1){1'b0}}, SatMax[IntWidth-2:0]});
         quot_ff <= (q_ff[QBits] > {{(QBits-IntWidth+1){1'b0}}, SatMax[IntWidth-2:0]})
                    ? SatMax[IntWidth-2:0] : q_ff[QBits][IntWidth-2:0];
      end
   end

   assign quot = quot_ff;
   assign ovf  = ovf_ff;
endmodule
`default_nettype wire

@@ dv/rational_lens_distortion_test.sv @@
// Self-checking testbench for the rational lens distortion pipeline.
// Needs rld_pkg and the rational_lens_distortion RTL; stands alone otherwise.
module rational_lens_distortion_test;
   import rld_pkg::*;

   localparam longint SatLimit = 64'sd549755813887;
   localparam longint OneQ24L = 64'sd16777216;
   localparam int DrainCycles = 64;
   localparam int CycleLimit = 400000;

   typedef struct {
      logic [31:0] x_dist;
      logic [31:0] y_dist;
      bit          range_error;
   } dist_point_type;

   // Predicts distorted points and holds those not yet returned by the block.
   class distortion_scoreboard;
      coef_type       coefs;
      dist_point_type pending_points[$];
      int             errors;
      int             accepted;

      function new();
         coefs = '0;
         errors = 0;
         accepted = 0;
      endfunction

      task automatic report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      function automatic longint clamp39(longint v, inout bit ovf);
         if (v > SatLimit) begin
            ovf = 1;
            return SatLimit;
         end
         if (v < -SatLimit) begin
            ovf = 1;
            return -SatLimit;
         end
         return v;
      endfunction

      function automatic logic [63:0] magnitude(longint v);
         return (v < 0) ? 64'(-v) : 64'(v);
      endfunction

      // Exact product, truncated toward zero by 2^sh, magnitude clamped.
      function automatic longint scaled_product(longint a, longint b, int sh, inout bit ovf);
         logic [127:0] prod;
         longint r;
         prod = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
         prod = prod >> sh;
         if (prod > 128'(SatLimit)) begin
            ovf = 1;
            r = SatLimit;
         end else begin
            r = longint'(prod[63:0]);
         end
         return ((a < 0) != (b < 0)) ? -r : r;
      endfunction

      // Horner evaluation of 1 + c1 r2 + c2 r2^2 + c3 r2^3 in Q.24.
      function automatic longint radial_poly(longint c1, longint c2, longint c3, longint r2,
                                             inout bit ovf);
         longint acc;
         acc = c3;
         acc = clamp39(c2 + scaled_product(acc, r2, 28, ovf), ovf);
         acc = clamp39(c1 + scaled_product(acc, r2, 28, ovf), ovf);
         return clamp39(OneQ24L + scaled_product(acc, r2, 28, ovf), ovf);
      endfunction

      function automatic logic [31:0] clamp32(longint v, inout bit ovf);
         if (v > 64'sd2147483647) begin
            ovf = 1;
            v = 64'sd2147483647;
         end
         if (v < -64'sd2147483648) begin
            ovf = 1;
            v = -64'sd2147483648;
         end
         return v[31:0];
      endfunction

      function automatic dist_point_type distort(logic [31:0] xin, logic [31:0] yin);
         dist_point_type pt;
         bit ovf;
         longint x, y, r2, xx, yy, xy, num, den, gain, rx, ry, dx, dy;
         logic [63:0] ax, ay, quot;
         ovf = 0;
         x = longint'($signed(xin));
         y = longint'($signed(yin));
         ax = magnitude(x);
         ay = magnitude(y);
         r2 = longint'((ax * ax + ay * ay) >> 28);
         xx = longint'((ax * ax) >> 28);
         yy = longint'((ay * ay) >> 28);
         xy = scaled_product(x, y, 28, ovf);
         num = radial_poly(longint'(coefs.k1), longint'(coefs.k2), longint'(coefs.k3), r2, ovf);
         den = radial_poly(longint'(coefs.k4), longint'(coefs.k5), longint'(coefs.k6), r2, ovf);
         // A vanishing denominator forces a zero point with the error flag.
         if (den == 0) begin
            pt.x_dist = '0;
            pt.y_dist = '0;
            pt.range_error = 1;
            return pt;
         end
         quot = (magnitude(num) << 24) / magnitude(den);
         if (quot > 64'(SatLimit)) begin
            ovf = 1;
            quot = 64'(SatLimit);
         end
         gain = ((num < 0) != (den < 0)) ? -longint'(quot) : longint'(quot);
         rx = scaled_product(x, gain, 24, ovf);
         ry = scaled_product(y, gain, 24, ovf);
         dx = clamp39(scaled_product(longint'(coefs.p1), 2 * xy, 24, ovf)
                      + scaled_product(longint'(coefs.p2), r2 + 2 * xx, 24, ovf), ovf);
         dy = clamp39(scaled_product(longint'(coefs.p1), r2 + 2 * yy, 24, ovf)
                      + scaled_product(longint'(coefs.p2), 2 * xy, 24, ovf), ovf);
         pt.x_dist = clamp32(rx + dx, ovf);
         pt.y_dist = clamp32(ry + dy, ovf);
         pt.range_error = ovf;
         return pt;
      endfunction

      function automatic void set_coef(reg_idx_type idx, logic [31:0] value);
         case (idx)
            REG_K1: coefs.k1 = value;
            REG_K2: coefs.k2 = value;
            REG_K3: coefs.k3 = value;
            REG_K4: coefs.k4 = value;
            REG_K5: coefs.k5 = value;
            REG_K6: coefs.k6 = value;
            REG_P1: coefs.p1 = value;
            REG_P2: coefs.p2 = value;
         endcase
      endfunction

      function automatic void note_input(logic [63:0] data);
         pending_points = {pending_points, distort(data[31:0], data[63:32])};
         accepted++;
      endfunction

      task automatic check_result(logic [63:0] data, logic flag);
         dist_point_type want;
         if (pending_points.size() == 0) begin
            report($sformatf("unexpected result %h", data));
            return;
         end
         want = pending_points.pop_front();
         if (data[31:0] !== want.x_dist)
            report($sformatf("x_dist %h, expected %h", data[31:0], want.x_dist));
         if (data[63:32] !== want.y_dist)
            report($sformatf("y_dist %h, expected %h", data[63:32], want.y_dist));
         if (flag !== want.range_error)
            report($sformatf("range_error %b, expected %b", flag, want.range_error));
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [63:0]            req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [63:0]            rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wr_en;
   logic [CsrIdxWidth-1:0] csr_idx;
   logic [CoefWidth-1:0]   csr_data;

   distortion_scoreboard sb = new();
   bit stall_held = 0;

   rational_lens_distortion dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_idx(csr_idx), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // No idling on either side during this stretch of the run.
   function automatic bit quiet_stretch();
      return sb.accepted >= 1000 && sb.accepted < 1300;
   endfunction

   // Random signed value spanning the given number of bits.
   function automatic logic [31:0] rand_span(int bits);
      return 32'($signed($urandom) >>> (32 - bits));
   endfunction

   function automatic logic [31:0] rand_coord();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return rand_span(29);
      if (pick < 90) return rand_span(31);
      return $urandom;
   endfunction

   // Observe transfers on both channels.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_input(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // Result side: random idling, plus one long hold-off once the stream is going.
   initial begin
      rsp_tready = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!stall_held && sb.accepted >= 600) begin
            stall_held = 1;
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
         end else begin
            rsp_tready <= quiet_stretch() || ($urandom_range(99) >= 15);
            @(posedge clock);
         end
      end
   end

   // Overall watchdog.
   initial begin
      repeat (CycleLimit) @(posedge clock);
      $display("CHECKS FAILED");
      $finish;
   end

   // Offer one point and hold it until the transfer happens.
   task automatic send_point(logic [31:0] x, logic [31:0] y);
      if (!quiet_stretch() && $urandom_range(99) < 15) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_coef(reg_idx_type idx, logic [31:0] value);
      csr_wr_en <= 1;
      csr_idx <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_wr_en <= 0;
      sb.set_coef(idx, value);
   endtask

   // Let every outstanding point come back before touching the registers.
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending_points.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_all(logic [31:0] k1, logic [31:0] k2, logic [31:0] k3,
                            logic [31:0] k4, logic [31:0] k5, logic [31:0] k6,
                            logic [31:0] p1, logic [31:0] p2);
      drain();
      write_coef(REG_K1, k1);
      write_coef(REG_K2, k2);
      write_coef(REG_K3, k3);
      write_coef(REG_K4, k4);
      write_coef(REG_K5, k5);
      write_coef(REG_K6, k6);
      write_coef(REG_P1, p1);
      write_coef(REG_P2, p2);
   endtask

   task automatic send_extremes();
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h0000_0000);
   endtask

   initial begin
      int span;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_wr_en = 0;
      csr_idx = '0;
      csr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed points with the coefficients at reset.
      send_point(32'h0, 32'h0);
      send_point(32'h1000_0000, 32'h0);
      send_point(32'h0, 32'hF000_0000);
      send_point(32'hF000_0000, 32'h0800_0000);
      send_extremes();

      // Every coefficient at its largest, then at its smallest.
      write_all('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1);
      send_extremes();
      send_point(32'h1000_0000, 32'h1000_0000);
      write_all(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_extremes();
      send_point(32'h0100_0000, 32'hFF00_0000);

      // Denominator of exactly zero at unit radius (k4 = -1.0).
      write_all(32'h0100_0000, 0, 0, 32'hFF00_0000, 0, 0, 32'h0010_0000, 32'hFFF0_0000);
      send_point(32'h1000_0000, 32'h0);
      send_point(32'h0, 32'hF000_0000);
      send_point(32'h0800_0000, 32'h0800_0000);

      // Random phases, each with its own coefficient scale.
      for (int phase = 0; phase < 6; phase++) begin
         span = (phase == 5) ? 32 : 22 + 2 * phase;
         write_all(rand_span(span), rand_span(span), rand_span(span), rand_span(span),
                   rand_span(span), rand_span(span), rand_span(span), rand_span(span));
         repeat (320) send_point(rand_coord(), rand_coord());
      end

      req_tvalid <= 0;
      @(posedge clock);
      for (int w = 0; w < 20000 && sb.pending_points.size() != 0; w++) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (sb.pending_points.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending_points.size()));
      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

@@ sim.f @@
hdl/rld_pkg.sv
hdl/rld_mul.sv
hdl/rld_div.sv
hdl/rational_lens_distortion.sv
dv/rational_lens_distortion_test.sv
